@@ rtl/rc_channel_to_servo_pulse_mapper_top_macros.svh @@
// Assertion macros shared by the servo pulse mapper RTL.
`ifndef RC_CHANNEL_TO_SERVO_PULSE_MAPPER_TOP_MACROS_SVH
`define RC_CHANNEL_TO_SERVO_PULSE_MAPPER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RCSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rcsm_pkg.sv @@
// Shared types, constants and helpers of the servo pulse mapper.
`default_nettype none
package rcsm_pkg;

	// Default sizes
	localparam int CHANNELS_DEF = 16;
	localparam int OUTPUTS_DEF  = 5;

	// Field widths
	localparam int OUT_IDX_W = 3;
	localparam int CH_IDX_W  = 4;
	localparam int VALUE_W   = 16;
	localparam int COUNT_W   = 8;
	localparam int PULSE_W   = 17;
	localparam int PERIOD_W  = 21;
	localparam int TICKS_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int SRC_W     = 4;
	localparam int FS_W      = 10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS    = 3'd5;

	// Opcodes
	localparam logic [1:0] OP_VALUE = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Arithmetic constants
	localparam logic [9:0]  VALUE_MAX    = 10'd1000;
	localparam logic [9:0]  TRIGGER_MAX  = 10'd1023;
	// ceil(2^30 / 1023): exact x / 1023 for x below 2^20
	localparam logic [20:0] TRIG_RECIP   = 21'd1049602;
	// ceil(2^37 / 625): exact y / 625 for y below 2^27
	localparam logic [27:0] PERIOD_RECIP = 28'd219902326;
	localparam logic [PULSE_W-1:0] PULSE_LIMIT = 17'h1FFFF;

	// Register reset values
	localparam logic [PERIOD_W-1:0] RST_PERIOD   = 21'd499712;
	localparam logic [63:0]         RST_MAP      = 64'h53210;
	localparam logic [63:0]         RST_TRIGGER  = 64'd16;
	localparam logic [63:0]         RST_FAILSAFE = 64'd537395712500;
	localparam logic [TICKS_W-1:0]  RST_TICKS    = 16'd500;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                 store_wr;
		logic                 arm;
		logic                 disarm;
		logic                 tick_inc;
		logic                 count_frame;
		logic                 count_zero;
		logic                 sel;
		logic                 scale_mul;
		logic                 scale_div;
		logic                 period_mul;
		logic                 period_div;
		logic                 load_out;
		logic                 last;
		logic [OUT_IDX_W-1:0] idx;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic enable;
		logic period_nz;
		logic armed;
		logic tick_hit;
		logic out_free;
	} dp_status_t;

	// Configuration data width: the widest register
	function automatic int cfg_width(input int outputs);
		int w;
		w = FS_W * outputs;
		return (w > PERIOD_W) ? w : PERIOD_W;
	endfunction

endpackage
`default_nettype wire

@@ rtl/rcsm_regs.sv @@
// Configuration register file of the servo pulse mapper.
`default_nettype none
module rcsm_regs #(
	parameter int OUTPUTS = rcsm_pkg::OUTPUTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [rcsm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rcsm_pkg::cfg_width(OUTPUTS)-1:0] cfg_data,
	output logic                                   enable,
	output logic [rcsm_pkg::PERIOD_W-1:0]          pwm_period,
	output logic [rcsm_pkg::SRC_W*OUTPUTS-1:0]     source_map,
	output logic [OUTPUTS-1:0]                     trigger_mask,
	output logic [rcsm_pkg::FS_W*OUTPUTS-1:0]      safe_values,
	output logic [rcsm_pkg::TICKS_W-1:0]           timeout_ticks
);
	import rcsm_pkg::*;

	logic                      enable_q;
	logic [PERIOD_W-1:0]       period_q;
	logic [SRC_W*OUTPUTS-1:0]  map_q;
	logic [OUTPUTS-1:0]        trigger_q;
	logic [FS_W*OUTPUTS-1:0]   failsafe_q;
	logic [TICKS_W-1:0]        ticks_q;

	// Decode writes by register index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			period_q   <= RST_PERIOD;
			map_q      <= RST_MAP[SRC_W*OUTPUTS-1:0];
			trigger_q  <= RST_TRIGGER[OUTPUTS-1:0];
			failsafe_q <= RST_FAILSAFE[FS_W*OUTPUTS-1:0];
			ticks_q    <= RST_TICKS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_PERIOD:   period_q   <= cfg_data[PERIOD_W-1:0];
				REG_MAP:      map_q      <= cfg_data[SRC_W*OUTPUTS-1:0];
				REG_TRIGGER:  trigger_q  <= cfg_data[OUTPUTS-1:0];
				REG_FAILSAFE: failsafe_q <= cfg_data[FS_W*OUTPUTS-1:0];
				REG_TICKS:    ticks_q    <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign enable        = enable_q;
	assign pwm_period    = period_q;
	assign source_map    = map_q;
	assign trigger_mask  = trigger_q;
	assign safe_values   = failsafe_q;
	assign timeout_ticks = ticks_q;

endmodule
`default_nettype wire

@@ rtl/rcsm_dp.sv @@
// Datapath: channel store, timeout counter, pulse arithmetic and output register.
`default_nettype none
`include "rc_channel_to_servo_pulse_mapper_top_macros.svh"
module rcsm_dp #(
	parameter int CHANNELS = rcsm_pkg::CHANNELS_DEF,
	parameter int OUTPUTS  = rcsm_pkg::OUTPUTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcsm_pkg::dp_cmd_t                   cmd,
	output rcsm_pkg::dp_status_t                status,
	input  logic [rcsm_pkg::CH_IDX_W-1:0]       channel_index,
	input  logic [rcsm_pkg::VALUE_W-1:0]        channel_value,
	input  logic [rcsm_pkg::COUNT_W-1:0]        frame_chans,
	input  logic                                enable,
	input  logic [rcsm_pkg::PERIOD_W-1:0]       pwm_period,
	input  logic [rcsm_pkg::SRC_W*OUTPUTS-1:0]  source_map,
	input  logic [OUTPUTS-1:0]                  trigger_mask,
	input  logic [rcsm_pkg::FS_W*OUTPUTS-1:0]   safe_values,
	input  logic [rcsm_pkg::TICKS_W-1:0]        timeout_ticks,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rcsm_pkg::OUT_IDX_W-1:0]      output_index,
	output logic [rcsm_pkg::PULSE_W-1:0]        pulse_steps,
	output logic                                is_failsafe,
	output logic                                last
);
	import rcsm_pkg::*;

	localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CntW   = $clog2(CHANNELS + 1);

	logic [VALUE_W-1:0] store_q [CHANNELS];
	logic [CntW-1:0]    count_q;
	logic [TICKS_W-1:0] silence_q;
	logic               armed_q;
	logic [TICKS_W-1:0] silence_next;

	logic [SRC_W-1:0]   src;
	logic               in_range;
	logic [VALUE_W-1:0] raw;
	logic [FS_W-1:0]    fsv;
	logic [9:0]         sel_val;

	logic [9:0]         val_q;
	logic               trig_q;
	logic               fs_q;
	logic [19:0]        x_q;
	logic [40:0]        r_full;
	logic [9:0]         w_q;
	logic [31:0]        prod_q;
	logic [54:0]        q_full;
	logic [17:0]        q_q;
	logic [PULSE_W-1:0] pulse_sat;

	logic                 out_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [PULSE_W-1:0]   out_pulse_q;
	logic                 out_fs_q;
	logic                 out_last_q;

	// Write channel values into the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd.store_wr && int'(channel_index) < CHANNELS) begin
			store_q[channel_index[ChIdxW-1:0]] <= channel_value;
		end
	end

	// Latch the clamped channel count, or zero to force all failsafe values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_frame) begin
			count_q <= (int'(frame_chans) > CHANNELS) ? CntW'(CHANNELS)
				: CntW'(frame_chans);
		end else if (cmd.count_zero) begin
			count_q <= '0;
		end
	end

	// Silence counter and timeout arming
	assign silence_next = silence_q + TICKS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q <= '0;
			armed_q   <= 1'b0;
		end else if (cmd.arm) begin
			silence_q <= '0;
			armed_q   <= 1'b1;
		end else if (cmd.disarm) begin
			silence_q <= '0;
			armed_q   <= 1'b0;
		end else if (cmd.tick_inc) begin
			silence_q <= silence_next;
		end
	end

	// Select the source value or the failsafe value for the current output
	always_comb begin
		src      = source_map[SRC_W*int'(cmd.idx) +: SRC_W];
		in_range = int'(src) < int'(count_q);
		raw      = in_range ? store_q[src[ChIdxW-1:0]] : '0;
		fsv      = safe_values[FS_W*int'(cmd.idx) +: FS_W];
		if (!in_range) begin
			sel_val = (fsv > VALUE_MAX) ? VALUE_MAX : fsv;
		end else if (trigger_mask[cmd.idx]) begin
			sel_val = (raw > VALUE_W'(TRIGGER_MAX)) ? TRIGGER_MAX : raw[9:0];
		end else begin
			sel_val = (raw > VALUE_W'(VALUE_MAX)) ? VALUE_MAX : raw[9:0];
		end
	end

	// Arithmetic products
	assign r_full = 41'(x_q) * 41'(TRIG_RECIP);
	assign q_full = 55'(prod_q[31:5]) * 55'(PERIOD_RECIP);
	assign pulse_sat = (q_q > 18'(PULSE_LIMIT)) ? PULSE_LIMIT : q_q[PULSE_W-1:0];

	// Step the per-output arithmetic under controller command
	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			val_q  <= sel_val;
			trig_q <= in_range && trigger_mask[cmd.idx];
			fs_q   <= !in_range;
		end
		if (cmd.scale_mul) begin
			x_q <= 20'(val_q) * 20'(VALUE_MAX);
		end
		if (cmd.scale_div) begin
			w_q <= trig_q ? r_full[39:30] : val_q;
		end
		if (cmd.period_mul) begin
			prod_q <= 32'(11'(VALUE_MAX) + 11'(w_q)) * 32'(pwm_period);
		end
		if (cmd.period_div) begin
			q_q <= q_full[54:37];
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q   <= cmd.idx;
			out_pulse_q <= pulse_sat;
			out_fs_q    <= fs_q;
			out_last_q  <= cmd.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign output_index = out_idx_q;
	assign pulse_steps  = out_pulse_q;
	assign is_failsafe  = out_fs_q;
	assign last         = out_last_q;

	// Status to the controller
	assign status.enable    = enable;
	assign status.period_nz = (pwm_period != '0);
	assign status.armed     = armed_q;
	assign status.tick_hit  = (silence_next >= timeout_ticks);
	assign status.out_free  = !out_valid_q || out_ready;

	`RCSM_ASSERT_NEXT(a_arm_clears_count, cmd.arm, armed_q && silence_q == '0, "arm did not restart silence count")
	`RCSM_ASSERT_NEXT(a_disarm_clears, cmd.disarm, !armed_q && silence_q == '0, "timeout did not disarm")

endmodule
`default_nettype wire

@@ rtl/rcsm_ctrl.sv @@
// Controller: decodes input items and sequences the per-output arithmetic.
`default_nettype none
`include "rc_channel_to_servo_pulse_mapper_top_macros.svh"
module rcsm_ctrl #(
	parameter int OUTPUTS = rcsm_pkg::OUTPUTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  rcsm_pkg::dp_status_t  status,
	output rcsm_pkg::dp_cmd_t     cmd
);
	import rcsm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEL  = 3'd1;
	localparam logic [2:0] ST_XMUL = 3'd2;
	localparam logic [2:0] ST_XDIV = 3'd3;
	localparam logic [2:0] ST_PMUL = 3'd4;
	localparam logic [2:0] ST_PDIV = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [OUT_IDX_W-1:0] idx_q, idx_d;
	logic                 take;
	logic                 last_out;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign last_out = (idx_q == OUT_IDX_W'(OUTPUTS - 1));

	// Decode the item and step through each output
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (opcode)
						OP_VALUE: begin
							cmd.store_wr = 1'b1;
						end
						OP_FRAME: begin
							if (status.enable) begin
								cmd.arm         = 1'b1;
								cmd.count_frame = 1'b1;
								if (status.period_nz) begin
									state_d = ST_SEL;
									idx_d   = '0;
								end
							end
						end
						OP_TICK: begin
							if (status.armed) begin
								if (status.tick_hit) begin
									cmd.disarm     = 1'b1;
									cmd.count_zero = 1'b1;
									if (status.enable && status.period_nz) begin
										state_d = ST_SEL;
										idx_d   = '0;
									end
								end else begin
									cmd.tick_inc = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_XMUL;
			end
			ST_XMUL: begin
				cmd.scale_mul = 1'b1;
				state_d       = ST_XDIV;
			end
			ST_XDIV: begin
				cmd.scale_div = 1'b1;
				state_d       = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.period_mul = 1'b1;
				state_d        = ST_PDIV;
			end
			ST_PDIV: begin
				cmd.period_div = 1'b1;
				state_d        = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					cmd.last     = last_out;
					if (last_out) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + OUT_IDX_W'(1);
						state_d = ST_SEL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	`RCSM_ASSERT_NEXT(a_run_starts_at_zero, state_q == ST_IDLE && state_d == ST_SEL, state_q == ST_SEL && idx_q == '0, "run did not start at output zero")
	`RCSM_ASSERT_NOW(a_idx_in_range, state_q != ST_IDLE, idx_q <= OUT_IDX_W'(OUTPUTS - 1), "output index beyond last output")
	`RCSM_ASSERT_NEXT(a_last_ends_run, cmd.load_out && cmd.last, state_q == ST_IDLE, "run did not end after last output")

endmodule
`default_nettype wire

@@ rtl/rc_channel_to_servo_pulse_mapper_top.sv @@
// Top level of the RC channel to servo pulse mapper.
`default_nettype none
// Channel value writes and millisecond ticks are taken while the block is idle. A frame
// end, or a tick that expires the link timeout, starts a run if enabled with a nonzero
// period, producing one result per servo output, in output order, with last set on the
// final one. Each output goes through a six-step sequence (select, trigger rescale
// multiply and reciprocal, period multiply and reciprocal, load of the output register);
// the load waits on out_ready while a result is held, and no new item is taken during a
// run. The output register lets the next output be computed while the previous result
// waits to be transferred. Configuration must be written only while the block is idle,
// through cfg_write/cfg_index/cfg_data; the block itself does not enforce this.
module rc_channel_to_servo_pulse_mapper_top #(
	parameter int CHANNELS = rcsm_pkg::CHANNELS_DEF,
	parameter int OUTPUTS  = rcsm_pkg::OUTPUTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [rcsm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rcsm_pkg::cfg_width(OUTPUTS)-1:0] cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              opcode,
	input  logic [rcsm_pkg::CH_IDX_W-1:0]           channel_index,
	input  logic [rcsm_pkg::VALUE_W-1:0]            channel_value,
	input  logic [rcsm_pkg::COUNT_W-1:0]            frame_chans,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [rcsm_pkg::OUT_IDX_W-1:0]          output_index,
	output logic [rcsm_pkg::PULSE_W-1:0]            pulse_steps,
	output logic                                    is_failsafe,
	output logic                                    last
);
	import rcsm_pkg::*;

	logic                      enable;
	logic [PERIOD_W-1:0]       pwm_period;
	logic [SRC_W*OUTPUTS-1:0]  source_map;
	logic [OUTPUTS-1:0]        trigger_mask;
	logic [FS_W*OUTPUTS-1:0]   safe_values;
	logic [TICKS_W-1:0]        timeout_ticks;
	dp_cmd_t                   cmd;
	dp_status_t                status;

	// Configuration registers
	rcsm_regs #(
		.OUTPUTS(OUTPUTS)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.enable       (enable),
		.pwm_period   (pwm_period),
		.source_map   (source_map),
		.trigger_mask (trigger_mask),
		.safe_values  (safe_values),
		.timeout_ticks(timeout_ticks)
	);

	// Sequencer
	rcsm_ctrl #(
		.OUTPUTS(OUTPUTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode  (opcode),
		.status  (status),
		.cmd     (cmd)
	);

	// Store, counters and arithmetic
	rcsm_dp #(
		.CHANNELS(CHANNELS),
		.OUTPUTS (OUTPUTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.frame_chans  (frame_chans),
		.enable       (enable),
		.pwm_period   (pwm_period),
		.source_map   (source_map),
		.trigger_mask (trigger_mask),
		.safe_values  (safe_values),
		.timeout_ticks(timeout_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.output_index (output_index),
		.pulse_steps  (pulse_steps),
		.is_failsafe  (is_failsafe),
		.last         (last)
	);

endmodule
`default_nettype wire
